[rtl/mmsr_pkg.sv]
// Shared constants, FSM types and modular add helper for the modular square root core.
// No dependencies.
`default_nettype none

package mmsr_pkg;

    localparam int WIDTH = 64;              // value bits used, sign bit at WIDTH-1
    localparam int XW    = 63;              // modulus and residue width
    localparam int ZW    = 13;              // non-residue candidate width
    localparam int CW    = 6;               // two-adic order / bit counters
    localparam logic [ZW-1:0] NR_LIMIT = ZW'(4096);

    typedef enum logic [4:0] {
        S_IDLE, S_RED, S_ACHK, S_POW, S_POW_MA, S_POW_MB, S_POWRET,
        S_FACTOR, S_ZTRY, S_TLOOP, S_SQ, S_SQCHK, S_BCHK, S_BSQ,
        S_MR, S_MC, S_MT, S_FIN, S_OUT
    } t_state;

    // what to do when an exponentiation finishes
    typedef enum logic [2:0] {
        P_EULER, P_ROOT3, P_ZCHK, P_C, P_R, P_T
    } t_pret;

    function automatic logic [XW-1:0] add_mod(input logic [XW-1:0] x,
                                              input logic [XW-1:0] y,
                                              input logic [XW-1:0] p);
        logic [XW:0] s;
        s = {1'b0, x} + {1'b0, y};
        return (s >= {1'b0, p}) ? XW'(s - {1'b0, p}) : XW'(s);
    endfunction

endpackage

`default_nettype wire

[rtl/mmsr_mul.sv]
// Bit-serial modular multiplier: double-and-add, one multiplier bit per cycle.
// Depends on mmsr_pkg.
`default_nettype none

module mmsr_mul import mmsr_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [XW-1:0] i_x,
    input  wire logic [XW-1:0] i_y,
    input  wire logic [XW-1:0] i_p,
    output logic               o_done,
    output logic [XW-1:0]      o_prod
);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [XW-1:0] r_x, r_y, r_p, r_acc;
    logic [XW-1:0] n_dbl, n_acc;

    always_comb begin
        n_dbl = add_mod(r_acc, r_acc, r_p);
        n_acc = r_y[XW-1] ? add_mod(n_dbl, r_x, r_p) : n_dbl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(XW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_p   <= i_p;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_y   <= {r_y[XW-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

[rtl/mmsr_red.sv]
// Bit-serial restoring remainder: 64-bit magnitude modulo a 63-bit modulus.
// Depends on mmsr_pkg.
`default_nettype none

module mmsr_red import mmsr_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [63:0]   i_mag,
    input  wire logic [XW-1:0] i_p,
    output logic               o_done,
    output logic [XW-1:0]      o_rem
);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [63:0]   r_mag;
    logic [XW-1:0] r_p, r_rem;
    logic [XW:0]   n_sh;
    logic [XW-1:0] n_rem;

    always_comb begin
        n_sh  = {r_rem, r_mag[63]};
        n_rem = (n_sh >= {1'b0, r_p}) ? XW'(n_sh - {1'b0, r_p}) : XW'(n_sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(63);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= i_mag;
            r_p   <= i_p;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_mag <= {r_mag[62:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

[rtl/modular_square_root_prime_core.sv]
// Modular square root modulo a prime (Tonelli-Shanks), one request at a time.
// The value is first reduced modulo the prime, then each exponentiation runs on the shared
// bit-serial multiplier; p mod 4 == 3 needs the Euler check and a direct root exponentiation,
// other primes add one exponentiation per non-residue candidate and the refinement loop.
// Requests are handled one at a time; a new request is taken while a result waits.
// Reset: synchronous active-low i_rst_n clears the sequencer and the output valid.
`default_nettype none

module modular_square_root_prime_core import mmsr_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [127:0] i_s_axis_tdata,   // [63:0] value, [126:64] prime_modulus
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [63:0]       o_m_axis_tdata,   // [62:0] root
    output logic              o_m_axis_tuser    // [0] has_root
);

    t_state r_state, n_state;
    t_pret  r_pret, n_pret;

    logic [XW-1:0] r_p, r_a, r_q, r_c, r_r, r_t, r_tt, r_b, r_pb, r_pe, r_pacc, r_root;
    logic [XW-1:0] n_p, n_a, n_q, n_c, n_r, n_t, n_tt, n_b, n_pb, n_pe, n_pacc, n_root;
    logic [CW-1:0] r_s, r_m, r_i, r_j, n_s, n_m, n_i, n_j;
    logic [ZW-1:0] r_z, r_lim, n_z, n_lim;
    logic          r_neg, n_neg, r_has, n_has;
    logic          r_ovalid, r_ohas;
    logic [XW-1:0] r_oroot;

    logic          acc_in, out_load;
    logic          red_done, mul_done, mul_start;
    logic [XW-1:0] red_rem, mul_prod, mul_x, mul_y;
    logic [XW-1:0] in_p, p_m1, p_mr;
    logic signed [WIDTH-1:0] in_vw;
    logic [63:0]   in_v, in_mag;
    logic          sq_more, sq_fail, b_more, z_out;

    assign acc_in   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load = (r_state == S_OUT) && (!r_ovalid || i_m_axis_tready);
    assign in_p     = i_s_axis_tdata[126:64];
    assign in_vw    = i_s_axis_tdata[WIDTH-1:0];
    assign in_v     = 64'(in_vw);
    assign in_mag   = in_v[63] ? (~in_v + 64'd1) : in_v;
    assign p_m1     = r_p - 1'b1;
    assign p_mr     = r_p - r_r;
    assign sq_more  = (r_i < r_m) && (r_tt != XW'(1));
    assign sq_fail  = (r_tt != XW'(1)) || (r_i >= r_m);
    assign b_more   = ({1'b0, r_j} + {1'b0, r_i} + 7'd1) < {1'b0, r_m};
    assign z_out    = r_z >= (r_lim + ZW'(2));

    mmsr_red u_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (acc_in && (in_p != '0)),
        .i_mag   (in_mag),
        .i_p     (in_p),
        .o_done  (red_done),
        .o_rem   (red_rem)
    );

    mmsr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .i_p     (r_p),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (acc_in) n_state = (in_p == '0) ? S_OUT : S_RED;
            S_RED:    if (red_done) n_state = S_ACHK;
            S_ACHK:   n_state = ((r_a == '0) || (r_p <= XW'(2))) ? S_OUT : S_POW;
            S_POW: begin
                if (r_pe == '0)      n_state = S_POWRET;
                else if (r_pe[0])    n_state = S_POW_MA;
                else                 n_state = S_POW_MB;
            end
            S_POW_MA: if (mul_done) n_state = S_POW_MB;
            S_POW_MB: if (mul_done) n_state = S_POW;
            S_POWRET: begin
                case (r_pret)
                    P_EULER: begin
                        if (r_pacc != XW'(1))    n_state = S_OUT;
                        else if (r_p[1:0] == 2'd3) n_state = S_POW;
                        else                     n_state = S_FACTOR;
                    end
                    P_ROOT3: n_state = S_FIN;
                    P_ZCHK:  n_state = (r_pacc == p_m1) ? S_POW : S_ZTRY;
                    P_C:     n_state = S_POW;
                    P_R:     n_state = S_POW;
                    P_T:     n_state = S_TLOOP;
                    default: n_state = S_IDLE;
                endcase
            end
            S_FACTOR: if (!((r_q != '0) && !r_q[0])) n_state = S_ZTRY;
            S_ZTRY:   n_state = z_out ? S_OUT : S_POW;
            S_TLOOP:  n_state = (r_t == XW'(1)) ? S_FIN : S_SQ;
            S_SQ:     if (mul_done) n_state = S_SQCHK;
            S_SQCHK: begin
                if (sq_more)      n_state = S_SQ;
                else if (sq_fail) n_state = S_OUT;
                else              n_state = S_BCHK;
            end
            S_BCHK:   n_state = b_more ? S_BSQ : S_MR;
            S_BSQ:    if (mul_done) n_state = S_BCHK;
            S_MR:     if (mul_done) n_state = S_MC;
            S_MC:     if (mul_done) n_state = S_MT;
            S_MT:     if (mul_done) n_state = S_TLOOP;
            S_FIN:    n_state = S_OUT;
            S_OUT:    if (out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and multiplier control
    always_comb begin
        n_pret = r_pret; n_p = r_p; n_a = r_a; n_q = r_q; n_c = r_c; n_r = r_r;
        n_t = r_t; n_tt = r_tt; n_b = r_b; n_pb = r_pb; n_pe = r_pe; n_pacc = r_pacc;
        n_root = r_root; n_s = r_s; n_m = r_m; n_i = r_i; n_j = r_j; n_z = r_z;
        n_lim = r_lim; n_neg = r_neg; n_has = r_has;
        mul_start = 1'b0; mul_x = r_pb; mul_y = r_pb;
        case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    n_p = in_p; n_neg = in_v[63];
                    n_has = 1'b0; n_root = '0;
                end
            end
            S_RED: begin
                if (red_done)
                    n_a = (r_neg && (red_rem != '0)) ? r_p - red_rem : red_rem;
            end
            S_ACHK: begin
                if ((r_a == '0) || (r_p <= XW'(2))) begin
                    n_has = 1'b1; n_root = r_a;
                end else begin
                    n_pb = r_a; n_pe = p_m1 >> 1; n_pacc = XW'(1); n_pret = P_EULER;
                end
            end
            S_POW: begin
                if (r_pe != '0) begin
                    mul_start = 1'b1;
                    mul_x = r_pe[0] ? r_pacc : r_pb;
                end
            end
            S_POW_MA: begin
                if (mul_done) begin
                    n_pacc = mul_prod; mul_start = 1'b1;
                end
            end
            S_POW_MB: begin
                if (mul_done) begin
                    n_pb = mul_prod; n_pe = r_pe >> 1;
                end
            end
            S_POWRET: begin
                case (r_pret)
                    P_EULER: begin
                        if (r_pacc != XW'(1)) begin
                            n_has = 1'b0; n_root = '0;
                        end else if (r_p[1:0] == 2'd3) begin
                            n_pb = r_a; n_pe = XW'(({1'b0, r_p} + 64'd1) >> 2);
                            n_pacc = XW'(1); n_pret = P_ROOT3;
                        end else begin
                            n_q = p_m1; n_s = '0;
                        end
                    end
                    P_ROOT3: n_r = r_pacc;
                    P_ZCHK: begin
                        if (r_pacc == p_m1) begin
                            n_pb = XW'(r_z); n_pe = r_q; n_pacc = XW'(1); n_pret = P_C;
                        end else begin
                            n_z = r_z + 1'b1;
                        end
                    end
                    P_C: begin
                        n_c = r_pacc; n_pb = r_a; n_pe = XW'(({1'b0, r_q} + 64'd1) >> 1);
                        n_pacc = XW'(1); n_pret = P_R;
                    end
                    P_R: begin
                        n_r = r_pacc; n_pb = r_a; n_pe = r_q; n_pacc = XW'(1); n_pret = P_T;
                    end
                    P_T: begin
                        n_t = r_pacc; n_m = r_s;
                    end
                    default: ;
                endcase
            end
            S_FACTOR: begin
                if ((r_q != '0) && !r_q[0]) begin
                    n_q = r_q >> 1; n_s = r_s + 1'b1;
                end else begin
                    n_z = ZW'(2);
                    n_lim = ((r_p - XW'(2)) < XW'(NR_LIMIT)) ? ZW'(r_p - XW'(2)) : NR_LIMIT;
                end
            end
            S_ZTRY: begin
                if (z_out) begin
                    n_has = 1'b0; n_root = '0;
                end else begin
                    n_pb = XW'(r_z); n_pe = p_m1 >> 1; n_pacc = XW'(1); n_pret = P_ZCHK;
                end
            end
            S_TLOOP: begin
                if (r_t != XW'(1)) begin
                    n_i = CW'(1); mul_start = 1'b1; mul_x = r_t; mul_y = r_t;
                end
            end
            S_SQ: if (mul_done) n_tt = mul_prod;
            S_SQCHK: begin
                if (sq_more) begin
                    n_i = r_i + 1'b1; mul_start = 1'b1; mul_x = r_tt; mul_y = r_tt;
                end else if (sq_fail) begin
                    n_has = 1'b0; n_root = '0;
                end else begin
                    n_b = r_c; n_j = '0;
                end
            end
            S_BCHK: begin
                mul_start = 1'b1;
                if (b_more) begin
                    mul_x = r_b; mul_y = r_b;
                end else begin
                    mul_x = r_r; mul_y = r_b;
                end
            end
            S_BSQ: begin
                if (mul_done) begin
                    n_b = mul_prod; n_j = r_j + 1'b1;
                end
            end
            S_MR: begin
                if (mul_done) begin
                    n_r = mul_prod; mul_start = 1'b1; mul_x = r_b; mul_y = r_b;
                end
            end
            S_MC: begin
                if (mul_done) begin
                    n_c = mul_prod; mul_start = 1'b1; mul_x = r_t; mul_y = mul_prod;
                end
            end
            S_MT: begin
                if (mul_done) begin
                    n_t = mul_prod; n_m = r_i;
                end
            end
            S_FIN: begin
                n_has = 1'b1;
                n_root = (r_r < p_mr) ? r_r : p_mr;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load)             r_ovalid <= 1'b1;
            else if (i_m_axis_tready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pret <= n_pret; r_p <= n_p; r_a <= n_a; r_q <= n_q; r_c <= n_c; r_r <= n_r;
        r_t <= n_t; r_tt <= n_tt; r_b <= n_b; r_pb <= n_pb; r_pe <= n_pe;
        r_pacc <= n_pacc; r_root <= n_root; r_s <= n_s; r_m <= n_m; r_i <= n_i;
        r_j <= n_j; r_z <= n_z; r_lim <= n_lim; r_neg <= n_neg; r_has <= n_has;
        if (out_load) begin
            r_ohas  <= r_has;
            r_oroot <= r_root;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {1'b0, r_oroot};
    assign o_m_axis_tuser  = r_ohas;

endmodule

`default_nettype wire

[rtl/mmsr_chk.sv]
// Port-level checker for the modular square root core, bound to the top level.
// Depends on modular_square_root_prime_core port names.
`default_nettype none

module mmsr_chk (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_axis_tvalid,
    input wire logic         o_s_axis_tready,
    input wire logic [127:0] i_s_axis_tdata,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [63:0]  o_m_axis_tdata,
    input wire logic         o_m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_no_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == 64'd0))
        else $error("nonzero root without has_root");

    // the reset edge itself clears the output valid
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !$rose(o_m_axis_tvalid))
        else $error("result appeared one cycle after request");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second request taken during work");

endmodule

bind modular_square_root_prime_core mmsr_chk u_mmsr_chk (.*);

`default_nettype wire
